[rtl/mfap_pkg.sv]
// Shared types and constants for the max-flow augmenting path block.
// Used by the interfaces, the controller, the datapath and the top level.
package mfap_pkg;

   localparam int NODE_IN_W   = 6;
   localparam int CAP_IN_W    = 16;
   localparam int FLOW_W      = 22;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int COUNT_W     = 7;
   localparam int START_BN    = 9999999;
   localparam int START_BN_W  = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE = 2'd0,
      CSR_SINK   = 2'd1,
      CSR_COUNT  = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_CLEAR,
      OP_LOAD,
      OP_START,
      OP_INIT,
      OP_CHECK,
      OP_SCAN_RD,
      OP_SCAN_CHK,
      OP_POP,
      OP_POP_LD,
      OP_PATH_BEGIN,
      OP_PATH_U,
      OP_PATH_W,
      OP_FWD,
      OP_REV,
      OP_DONE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } mfap_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic last_fire;
      logic src_ok;
      logic at_sink;
      logic scan_end;
      logic push_ok;
      logic last_level;
      logic path_end;
      logic rsp_free;
   } mfap_stat_type;

endpackage

[rtl/mfap_req_if.sv]
// Edge input channel: valid/ready handshake with one directed edge per transfer.
// Depends on mfap_pkg for field widths.
interface mfap_req_if;
   logic                             valid;
   logic                             ready;
   logic [mfap_pkg::NODE_IN_W-1:0]   from_node;
   logic [mfap_pkg::NODE_IN_W-1:0]   to_node;
   logic [mfap_pkg::CAP_IN_W-1:0]    edge_capacity;
   logic                             last_edge;

   modport source (output valid, from_node, to_node, edge_capacity, last_edge, input ready);
   modport sink (input valid, from_node, to_node, edge_capacity, last_edge, output ready);
endinterface

[rtl/mfap_rsp_if.sv]
// Result channel: valid/ready handshake carrying the total maximum flow.
// Depends on mfap_pkg for the field width.
interface mfap_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mfap_pkg::FLOW_W-1:0]   max_flow;

   modport source (output valid, max_flow, input ready);
   modport sink (input valid, max_flow, output ready);
endinterface

[rtl/mfap_csr_if.sv]
// Configuration write channel: register index and write data per transfer.
// Depends on mfap_pkg for field widths.
interface mfap_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mfap_pkg::CSR_IDX_W-1:0]    index;
   logic [mfap_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/max_flow_augmenting_paths_top.sv]
// Edges stream in at one transfer per cycle while loading, into a residual
// capacity memory of MAX_NODES x MAX_NODES entries (rounded up to a power of two
// per side). The edge marked last_edge starts the max-flow search, and input
// stalls until the result is produced and the memory is cleared again. Each
// neighbor tried takes one memory read plus its check, a step down to a new node
// adds a check of that node, a neighbor list that runs out ends on a last read
// step, and the backtrack that follows reloads the stack entry (a pop, then a
// load) and checks it. Applying a found path takes a begin step and a setup step,
// then a read, a forward write and a reverse write per edge on the path, all
// bound by the residual memory's one read port and one write port. After reset
// and after every result a clearing pass writes every entry before input is taken.
// Configuration writes are always taken but belong to idle periods only.
module max_flow_augmenting_paths_top #(
   parameter int MAX_NODES     = 64,
   parameter int CAPACITY_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   mfap_req_if.sink   req_if,
   mfap_rsp_if.source rsp_if,
   mfap_csr_if.sink   csr_if
);

   logic [mfap_pkg::NODE_IN_W-1:0] cfg_source_ff;
   logic [mfap_pkg::NODE_IN_W-1:0] cfg_sink_ff;
   logic [mfap_pkg::COUNT_W-1:0]   cfg_count_ff;

   mfap_pkg::mfap_cmd_type  cmd;
   mfap_pkg::mfap_stat_type stat;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_source_ff <= mfap_pkg::NODE_IN_W'(0);
         cfg_sink_ff <= mfap_pkg::NODE_IN_W'(1);
         cfg_count_ff <= mfap_pkg::COUNT_W'(64);
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            mfap_pkg::CSR_SOURCE: cfg_source_ff <= csr_if.data[mfap_pkg::NODE_IN_W-1:0];
            mfap_pkg::CSR_SINK:   cfg_sink_ff <= csr_if.data[mfap_pkg::NODE_IN_W-1:0];
            mfap_pkg::CSR_COUNT:  cfg_count_ff <= csr_if.data;
            default: begin
            end
         endcase
      end
   end

   mfap_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   mfap_dpath #(
      .MAX_NODES     (MAX_NODES),
      .CAPACITY_BITS (CAPACITY_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .cfg_source    (cfg_source_ff),
      .cfg_sink      (cfg_sink_ff),
      .cfg_count     (cfg_count_ff),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .from_node     (req_if.from_node),
      .to_node       (req_if.to_node),
      .edge_capacity (req_if.edge_capacity),
      .last_edge     (req_if.last_edge),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .max_flow      (rsp_if.max_flow)
   );

   // The final edge hands control to the search, so input must stall next cycle.
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.last_edge) |=> !req_if.ready)
      else $error("input still ready after final edge transfer");

   // A new result appears only out of the completion step.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(cmd.op == mfap_pkg::OP_DONE))
      else $error("result raised outside completion");

   // The clearing pass ends exactly at its last address and reopens input.
   a_clear_to_load: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == mfap_pkg::OP_CLEAR && stat.clr_last) |=> req_if.ready)
      else $error("input not reopened after clearing pass");

endmodule

[rtl/mfap_ctrl.sv]
// Sequencer for edge loading, depth-first search, path update and clearing.
// Depends on mfap_pkg for the command and status structs.
module mfap_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  mfap_pkg::mfap_stat_type stat,
   output mfap_pkg::mfap_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_LOAD,
      ST_START,
      ST_INIT,
      ST_CHECK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_POP,
      ST_POP_LD,
      ST_PATH_BEGIN,
      ST_PATH_U,
      ST_PATH_W,
      ST_FWD,
      ST_REV,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:      if (stat.clr_last) state_in = ST_LOAD;
         ST_LOAD:       if (stat.last_fire) state_in = ST_START;
         ST_START:      state_in = stat.src_ok ? ST_INIT : ST_DONE;
         ST_INIT:       state_in = ST_CHECK;
         ST_CHECK:      state_in = stat.at_sink ? ST_PATH_BEGIN : ST_SCAN_RD;
         ST_SCAN_RD:    state_in = stat.scan_end ? ST_POP : ST_SCAN_CHK;
         ST_SCAN_CHK:   state_in = stat.push_ok ? ST_CHECK : ST_SCAN_RD;
         ST_POP:        state_in = stat.last_level ? ST_DONE : ST_POP_LD;
         ST_POP_LD:     state_in = ST_CHECK;
         ST_PATH_BEGIN: state_in = ST_PATH_U;
         ST_PATH_U:     state_in = ST_PATH_W;
         ST_PATH_W:     state_in = ST_FWD;
         ST_FWD:        state_in = ST_REV;
         ST_REV:        state_in = stat.path_end ? ST_INIT : ST_PATH_W;
         ST_DONE:       if (stat.rsp_free) state_in = ST_CLEAR;
         default:       state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_CLEAR:      cmd.op = mfap_pkg::OP_CLEAR;
         ST_LOAD:       cmd.op = mfap_pkg::OP_LOAD;
         ST_START:      cmd.op = mfap_pkg::OP_START;
         ST_INIT:       cmd.op = mfap_pkg::OP_INIT;
         ST_CHECK:      cmd.op = mfap_pkg::OP_CHECK;
         ST_SCAN_RD:    cmd.op = mfap_pkg::OP_SCAN_RD;
         ST_SCAN_CHK:   cmd.op = mfap_pkg::OP_SCAN_CHK;
         ST_POP:        cmd.op = mfap_pkg::OP_POP;
         ST_POP_LD:     cmd.op = mfap_pkg::OP_POP_LD;
         ST_PATH_BEGIN: cmd.op = mfap_pkg::OP_PATH_BEGIN;
         ST_PATH_U:     cmd.op = mfap_pkg::OP_PATH_U;
         ST_PATH_W:     cmd.op = mfap_pkg::OP_PATH_W;
         ST_FWD:        cmd.op = mfap_pkg::OP_FWD;
         ST_REV:        cmd.op = mfap_pkg::OP_REV;
         ST_DONE:       cmd.op = mfap_pkg::OP_DONE;
         default:       cmd.op = mfap_pkg::OP_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/mfap_dpath.sv]
// Datapath: residual capacity memory, search stack memory, visited marks,
// bottleneck and flow arithmetic, and the result register. Depends on mfap_pkg.
module mfap_dpath #(
   parameter int MAX_NODES     = 64,
   parameter int CAPACITY_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mfap_pkg::mfap_cmd_type            cmd,
   output mfap_pkg::mfap_stat_type           stat,
   input  logic [mfap_pkg::NODE_IN_W-1:0]    cfg_source,
   input  logic [mfap_pkg::NODE_IN_W-1:0]    cfg_sink,
   input  logic [mfap_pkg::COUNT_W-1:0]      cfg_count,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mfap_pkg::NODE_IN_W-1:0]    from_node,
   input  logic [mfap_pkg::NODE_IN_W-1:0]    to_node,
   input  logic [mfap_pkg::CAP_IN_W-1:0]     edge_capacity,
   input  logic                              last_edge,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mfap_pkg::FLOW_W-1:0]       max_flow
);

   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = $clog2(MAX_NODES + 1);
   localparam int RES_W     = CAPACITY_BITS + NODE_W + 1;
   localparam int BN_W      = (RES_W > mfap_pkg::START_BN_W) ? RES_W : mfap_pkg::START_BN_W;
   localparam int ADDR_W    = 2 * NODE_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int VIS_DEPTH = 1 << NODE_W;
   localparam logic [mfap_pkg::CAP_IN_W-1:0] CAP_MASK = (CAPACITY_BITS >= mfap_pkg::CAP_IN_W) ?
      {mfap_pkg::CAP_IN_W{1'b1}} : mfap_pkg::CAP_IN_W'((32'd1 << CAPACITY_BITS) - 32'd1);

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [CNT_W-1:0]  scan;
      logic [BN_W-1:0]   bn;
   } stack_entry_type;

   logic [RES_W-1:0]    res_mem [MEM_DEPTH];
   stack_entry_type     stk_mem [MAX_NODES];

   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [NODE_W-1:0]   cur_node_ff, cur_node_in;
   logic [CNT_W-1:0]    cur_scan_ff, cur_scan_in;
   logic [BN_W-1:0]     cur_bn_ff, cur_bn_in;
   logic [CNT_W-1:0]    depth_ff, depth_in;
   logic [CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]    kk_ff, kk_in;
   logic [NODE_W-1:0]   u_ff, u_in;
   logic [NODE_W-1:0]   w_ff, w_in;
   logic [RES_W-1:0]    d_ff, d_in;
   logic [RES_W-1:0]    total_ff, total_in;
   logic [VIS_DEPTH-1:0] visited_ff, visited_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [mfap_pkg::FLOW_W-1:0] max_flow_ff, max_flow_in;
   logic [RES_W-1:0]    res_rd_ff;
   stack_entry_type     stk_rd_ff;

   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [RES_W-1:0]    mem_wdata;
   logic                stk_we;
   logic [NODE_W-1:0]   stk_waddr, stk_raddr;
   stack_entry_type     stk_wdata;

   logic [CNT_W-1:0]    n_eff;
   logic [NODE_W-1:0]   src_idx, sink_idx, scan_node, w_sel;
   logic [CNT_W-1:0]    top_idx;
   logic [BN_W-1:0]     cand_bn, new_bn;
   logic                req_fire, edge_in_range, rsp_free;

   always_comb begin
      n_eff = (32'(cfg_count) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(cfg_count);
      src_idx = NODE_W'(cfg_source);
      sink_idx = NODE_W'(cfg_sink);
      scan_node = scan_idx_ff[NODE_W-1:0];
      top_idx = depth_ff - CNT_W'(1);
      req_ready = (cmd.op == mfap_pkg::OP_LOAD);
      req_fire = req_valid && req_ready;
      edge_in_range = (32'(from_node) < MAX_NODES) && (32'(to_node) < MAX_NODES);
      rsp_free = !rsp_valid_ff || rsp_ready;
      cand_bn = BN_W'(res_rd_ff);
      new_bn = (cand_bn < cur_bn_ff) ? cand_bn : cur_bn_ff;

      stat.clr_last = &clr_addr_ff;
      stat.last_fire = req_fire && last_edge;
      stat.src_ok = (32'(cfg_source) < 32'(n_eff)) && (32'(cfg_sink) < 32'(n_eff)) &&
                    (cfg_source != cfg_sink);
      stat.at_sink = (cur_node_ff == sink_idx);
      stat.scan_end = (scan_idx_ff >= n_eff);
      stat.push_ok = (res_rd_ff != '0) && !visited_ff[scan_node] &&
                     (32'(depth_ff) < MAX_NODES);
      stat.last_level = (depth_ff == CNT_W'(1));
      stat.path_end = (kk_ff == top_idx);
      stat.rsp_free = rsp_free;
      // The last hop of a path ends at the node held in the top-of-stack registers.
      w_sel = stat.path_end ? cur_node_ff : stk_rd_ff.node;
   end

   always_comb begin
      clr_addr_in = clr_addr_ff;
      cur_node_in = cur_node_ff;
      cur_scan_in = cur_scan_ff;
      cur_bn_in = cur_bn_ff;
      depth_in = depth_ff;
      scan_idx_in = scan_idx_ff;
      kk_in = kk_ff;
      u_in = u_ff;
      w_in = w_ff;
      d_in = d_ff;
      total_in = total_ff;
      visited_in = visited_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      max_flow_in = max_flow_ff;
      mem_we = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_raddr = '0;
      stk_we = 1'b0;
      stk_waddr = '0;
      stk_wdata = '0;
      stk_raddr = '0;

      unique case (cmd.op)
         mfap_pkg::OP_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            total_in = '0;
         end
         mfap_pkg::OP_LOAD: begin
            if (req_fire && edge_in_range) begin
               mem_we = 1'b1;
               mem_waddr = {NODE_W'(from_node), NODE_W'(to_node)};
               mem_wdata = RES_W'(edge_capacity & CAP_MASK);
            end
         end
         mfap_pkg::OP_INIT: begin
            visited_in = '0;
            visited_in[src_idx] = 1'b1;
            cur_node_in = src_idx;
            cur_scan_in = '0;
            cur_bn_in = BN_W'(mfap_pkg::START_BN);
            depth_in = CNT_W'(1);
         end
         mfap_pkg::OP_CHECK: begin
            scan_idx_in = cur_scan_ff;
         end
         mfap_pkg::OP_SCAN_RD: begin
            mem_raddr = {cur_node_ff, scan_node};
         end
         mfap_pkg::OP_SCAN_CHK: begin
            if (stat.push_ok) begin
               stk_we = 1'b1;
               stk_waddr = top_idx[NODE_W-1:0];
               stk_wdata.node = cur_node_ff;
               stk_wdata.scan = scan_idx_ff + CNT_W'(1);
               stk_wdata.bn = cur_bn_ff;
               cur_node_in = scan_node;
               cur_scan_in = '0;
               cur_bn_in = new_bn;
               visited_in[scan_node] = 1'b1;
               depth_in = depth_ff + CNT_W'(1);
            end else begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
         end
         mfap_pkg::OP_POP: begin
            depth_in = depth_ff - CNT_W'(1);
            stk_raddr = NODE_W'(depth_ff - CNT_W'(2));
         end
         mfap_pkg::OP_POP_LD: begin
            cur_node_in = stk_rd_ff.node;
            cur_scan_in = stk_rd_ff.scan;
            cur_bn_in = stk_rd_ff.bn;
         end
         mfap_pkg::OP_PATH_BEGIN: begin
            d_in = RES_W'(cur_bn_ff);
            total_in = total_ff + RES_W'(cur_bn_ff);
            kk_in = CNT_W'(1);
            stk_raddr = '0;
         end
         mfap_pkg::OP_PATH_U: begin
            u_in = stk_rd_ff.node;
            stk_raddr = kk_ff[NODE_W-1:0];
         end
         mfap_pkg::OP_PATH_W: begin
            w_in = w_sel;
            mem_raddr = {u_ff, w_sel};
         end
         mfap_pkg::OP_FWD: begin
            mem_we = 1'b1;
            mem_waddr = {u_ff, w_ff};
            mem_wdata = res_rd_ff - d_ff;
            mem_raddr = {w_ff, u_ff};
         end
         mfap_pkg::OP_REV: begin
            mem_we = 1'b1;
            mem_waddr = {w_ff, u_ff};
            mem_wdata = res_rd_ff + d_ff;
            if (!stat.path_end) begin
               u_in = w_ff;
               kk_in = kk_ff + CNT_W'(1);
               stk_raddr = NODE_W'(kk_ff + CNT_W'(1));
            end
         end
         mfap_pkg::OP_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               max_flow_in = mfap_pkg::FLOW_W'(total_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         res_mem[mem_waddr] <= mem_wdata;
      end
      res_rd_ff <= res_mem[mem_raddr];
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         depth_ff <= '0;
         total_ff <= '0;
         visited_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         depth_ff <= depth_in;
         total_ff <= total_in;
         visited_ff <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_node_ff <= cur_node_in;
      cur_scan_ff <= cur_scan_in;
      cur_bn_ff <= cur_bn_in;
      scan_idx_ff <= scan_idx_in;
      kk_ff <= kk_in;
      u_ff <= u_in;
      w_ff <= w_in;
      d_ff <= d_in;
      max_flow_ff <= max_flow_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign max_flow = max_flow_ff;

endmodule
